// File: rtl/core/top_k_fitness_selector_top_defines.svh
// ----------------------------------------------------------------------------
// Top-k fitness selector: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TOP_K_FITNESS_SELECTOR_TOP_DEFINES_SVH
`define TOP_K_FITNESS_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define TKFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tkfs same-cycle check failed");

// Next-cycle implication.
`define TKFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tkfs next-cycle check failed");

`endif

// File: rtl/core/tkfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k fitness selector package
// Field widths and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tkfs_pkg;

  localparam int FIT_W     = 32;
  localparam int IDX_W     = 10;
  localparam int RANK_W    = 4;
  localparam int KEEP_CFG_W = 5;
  localparam logic [KEEP_CFG_W-1:0] KEEP_RESET = 5'd16;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'hF;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic              insert;     // accepted item; enters the cells unless past MAX_AGENTS
    logic              emit;       // load head into output register, shift up
    logic              emit_last;  // the entry being loaded ends the run
    logic              clear;      // reset list, position and overflow flag
    logic [RANK_W-1:0] rank;       // rank of the entry being loaded
  } dp_cmd_t;

  typedef struct packed {
    logic empty;     // no kept entries
    logic one_left;  // exactly one kept entry
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/top_k_fitness_selector_top.sv
// ----------------------------------------------------------------------------
// Top-k fitness selector
// Keeps the fittest items of a population and reads them out best first.
//
// Input stream (s_*): one signed fitness per transfer, population order;
//   s_tlast marks the final item. Items are numbered internally from 0.
// Output stream (m_*): one kept entry per transfer, rank 0 first; m_tlast
//   marks the final entry, m_tuser flags that the population overran
//   MAX_AGENTS (extra items are not ranked but still end the population).
// Configuration: cfg_wen/cfg_wdata write keep_count while the block is idle.
// Throughput: one input item per cycle while collecting; the insertion into
//   the compare-and-shift cells completes in the cycle of the transfer.
// Readout: the last item's transfer moves the controller to readout, where it
//   loads the output register, then one result per cycle while m_tready is high;
//   input is held off for the readout of up to min(kept, 16) entries.
// Stall: the output register holds its entry while m_tready is low, and the
//   list shift pauses with it.
// Reset: empty list, item count zero, keep_count back to 16.
// ----------------------------------------------------------------------------
`default_nettype none

`include "top_k_fitness_selector_top_defines.svh"

module top_k_fitness_selector_top
  import tkfs_pkg::*;
#(
  parameter int MAX_KEEP   = 16,
  parameter int MAX_AGENTS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_wen,
  input  wire logic [KEEP_CFG_W-1:0] cfg_wdata,   // keep_count
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [FIT_W-1:0]      s_tdata,     // [31:0] fitness
  input  wire logic                  s_tlast,     // last item of population
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,     // [3:0] rank, [13:4] agent_index,
                                                  // [45:14] kept_fitness, [47:46] zero
  output logic                       m_tlast,     // last_of_run
  output logic                       m_tuser      // overflow
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing: collect items, then drain the list through the output register.
  tkfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Cells, counters and the output payload.
  tkfs_datapath #(
    .MAX_KEEP   (MAX_KEEP),
    .MAX_AGENTS (MAX_AGENTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_fitness (signed'(s_tdata)),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (m_tdata),
    .out_last   (m_tlast),
    .out_ovf    (m_tuser)
  );

  // Insertion and readout never share a cycle.
  `TKFS_ASSERT_SAME(a_insert_emit_excl, cmd.insert, !cmd.emit)
  // The last item hands over to the readout at once.
  `TKFS_ASSERT_NEXT(a_last_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready)
  // Ending a readout leaves an empty list ready for the next population.
  `TKFS_ASSERT_NEXT(a_clear_empties, cmd.clear, stat.empty && s_tready)

endmodule

`default_nettype wire

// File: rtl/core/tkfs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k fitness selector datapath
// Compare-and-shift cells, item counter, keep_count register, output register.
// ----------------------------------------------------------------------------
module tkfs_datapath
  import tkfs_pkg::*;
#(
  parameter int MAX_KEEP   = 16,
  parameter int MAX_AGENTS = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wen,
  input  wire logic [KEEP_CFG_W-1:0]   cfg_wdata,
  input  wire logic signed [FIT_W-1:0] in_fitness,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  output logic [OUT_DATA_W-1:0]        out_data,
  output logic                         out_last,
  output logic                         out_ovf
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int POS_W = $clog2(MAX_AGENTS + 1);
  localparam int KW    = (CNT_W > KEEP_CFG_W) ? CNT_W : KEEP_CFG_W;

  logic [KEEP_CFG_W-1:0]   keep_count;
  logic [CNT_W-1:0]        filled;
  logic [POS_W-1:0]        pos;
  logic                    ovf_seen;

  logic signed [FIT_W-1:0] fit_q [MAX_KEEP];
  logic [IDX_W-1:0]        idx_q [MAX_KEEP];

  logic [RANK_W-1:0]       out_rank;
  logic [IDX_W-1:0]        out_idx;
  logic signed [FIT_W-1:0] out_fit;

  logic [KW-1:0]           kc_ext;
  logic [KW-1:0]           kc_min;
  logic [KW-1:0]           kc_lim;
  logic [CNT_W-1:0]        k_eff;
  logic [CNT_W-1:0]        fill_eff;
  logic [CNT_W-1:0]        fill_grow;
  logic [MAX_KEEP-1:0]     ins;
  logic [MAX_KEEP-1:0]     first;
  logic                    pos_ok;
  logic                    take;
  logic [POS_W+IDX_W-1:0]  pos_ext;
  logic [IDX_W-1:0]        item_idx;

  // Effective keep count: zero means one, clip to the cell count.
  always_comb begin
    kc_ext   = KW'(keep_count);
    kc_min   = (kc_ext == '0) ? KW'(1) : kc_ext;
    kc_lim   = (kc_min > KW'(MAX_KEEP)) ? KW'(MAX_KEEP) : kc_min;
    k_eff    = kc_lim[CNT_W-1:0];
    fill_eff = (filled > k_eff) ? k_eff : filled;
    fill_grow = (fill_eff < k_eff) ? fill_eff + CNT_W'(1) : k_eff;
  end

  assign pos_ok   = pos < POS_W'(MAX_AGENTS);
  assign take     = cmd.insert && pos_ok;
  assign pos_ext  = (POS_W + IDX_W)'(pos);
  assign item_idx = pos_ext[IDX_W-1:0];

  // A cell within the keep count takes a new value when the newcomer beats it or it is an empty slot.
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      ins[i] = (CNT_W'(i) < k_eff) &&
               ((CNT_W'(i) >= fill_eff) || (in_fitness > fit_q[i]));
    end
  end

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign first[g] = ins[g];
    end else begin : g_body
      assign first[g] = ins[g] && !ins[g-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.emit) begin
        // shift towards the head while the list is read out
        if (g < MAX_KEEP - 1) begin
          fit_q[g] <= fit_q[(g + 1) % MAX_KEEP];
          idx_q[g] <= idx_q[(g + 1) % MAX_KEEP];
        end
      end else if (take && ins[g]) begin
        if (first[g]) begin
          fit_q[g] <= in_fitness;
          idx_q[g] <= item_idx;
        end else begin
          fit_q[g] <= fit_q[(g + MAX_KEEP - 1) % MAX_KEEP];
          idx_q[g] <= idx_q[(g + MAX_KEEP - 1) % MAX_KEEP];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
      filled     <= '0;
      pos        <= '0;
      ovf_seen   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        keep_count <= cfg_wdata;
      end
      if (cmd.clear) begin
        filled   <= '0;
        pos      <= '0;
        ovf_seen <= 1'b0;
      end else if (cmd.emit) begin
        filled <= filled - CNT_W'(1);
      end else if (cmd.insert) begin
        if (pos_ok) begin
          filled <= (|ins) ? fill_grow : fill_eff;
          pos    <= pos + POS_W'(1);
        end else begin
          filled   <= fill_eff;
          ovf_seen <= 1'b1;
        end
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rank <= cmd.rank;
      out_idx  <= idx_q[0];
      out_fit  <= fit_q[0];
      out_last <= cmd.emit_last;
      out_ovf  <= ovf_seen;
    end
  end

  assign out_data = {(OUT_DATA_W - FIT_W - IDX_W - RANK_W)'(0), out_fit, out_idx, out_rank};

  assign stat.empty    = (filled == '0);
  assign stat.one_left = (filled == CNT_W'(1));

endmodule

`default_nettype wire

// File: rtl/core/tkfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k fitness selector controller
// Collect/readout sequencing and the output valid flag.
// ----------------------------------------------------------------------------
module tkfs_ctrl
  import tkfs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  input  wire logic     s_tlast,
  output logic          s_tready,
  input  wire logic     m_tready,
  output logic          m_tvalid,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [RANK_W-1:0] rank;
  logic              accept_in;
  logic              out_free;

  assign s_tready  = (state == ST_COLLECT);
  assign accept_in = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    cmd.insert    = accept_in;
    cmd.emit      = (state == ST_EMIT) && out_free && !stat.empty;
    cmd.emit_last = cmd.emit && (stat.one_left || (rank == RANK_MAX));
    cmd.clear     = cmd.emit_last || ((state == ST_EMIT) && stat.empty);
    cmd.rank      = rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      rank     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_COLLECT: begin
          rank <= '0;
          if (accept_in && s_tlast) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.emit) begin
            rank <= rank + RANK_W'(1);
          end
          if (cmd.clear) begin
            state <= ST_COLLECT;
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
